>>> rtl/bfrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfrf_pkg : shared types and constants of the free run finder
// Word geometry, position widths, request kinds, sequencer states and the
// structs that pass between the sequencer and the run mask unit.
// ----------------------------------------------------------------------------
package bfrf_pkg;

  // bitmap geometry
  localparam int WORD_BITS    = 64;
  localparam int BITMAP_WORDS = 64;
  localparam int ADDR_W       = $clog2(BITMAP_WORDS);
  localparam int CNT_W        = 7;
  localparam int POS_W        = 12;
  localparam int RUN_W        = 7;
  localparam int MAX_RUN      = WORD_BITS;
  localparam int CFG_RESET    = 64;

  // two-word search window and its helpers
  localparam int WIN_W  = 2 * WORD_BITS;
  localparam int SEL_W  = $clog2(WIN_W);
  localparam int LVL_N  = $clog2(WORD_BITS) + 1;
  localparam int LVL_W  = $clog2(LVL_N);
  localparam int SHF_W  = $clog2(WORD_BITS);

  // request kinds carried on tuser
  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_FIND  = 1'b1
  } bfrf_kind_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } bfrf_state_e;

  // tag that follows one bitmap word through the pipeline
  typedef struct packed {
    logic              vld;
    logic              last;
    logic [ADDR_W-1:0] widx;
  } bfrf_tag_t;

  // sequencer to run mask unit control
  typedef struct packed {
    logic             clr;
    logic [RUN_W-1:0] run_len;
    bfrf_tag_t        tag;
  } bfrf_ctl_t;

endpackage
`default_nettype wire

>>> rtl/bitmap_free_run_finder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_free_run_finder_core : first-fit free run finder over a bitmap
// Keeps 64 words of 64 bits (set bit = used) and answers find requests with
// the lowest start of a run of clear bits, across word boundaries.
// ----------------------------------------------------------------------------
// A write request (tuser 0) stores one word and gives no result. A find
// request (tuser 1) reads one bitmap word per cycle from the store's read
// port, words 0 to words_in_use-1, and passes each one through the shared
// run mask unit with the previous word's free bits. A search reads no words
// when the run length is zero, above 64 or no words are in use. The block
// takes no request while a search runs; a finished result waits in the
// output register. Words that were never written must not be searched.
// words_in_use above 64 searches 64 words; it is to be written only while
// idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module bitmap_free_run_finder_core
  import bfrf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // request: tdata = word_index[5:0], word_data[69:6], run_length[76:70]
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [79:0]       s_axis_tdata,
  input  wire logic              s_axis_tuser,   // kind
  // result: tdata = start_position[11:0]
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [15:0]            m_axis_tdata,
  output logic                   m_axis_tuser,   // found
  // words_in_use register
  input  wire logic              cfg_we_i,
  input  wire logic [CNT_W-1:0]  cfg_wdata_i
);

  logic [CNT_W-1:0]     words_q, words_d;
  logic [CNT_W-1:0]     limit;
  logic                 s_accept, st_we;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic [WORD_BITS-1:0] rdata;
  bfrf_ctl_t            ctl;
  bfrf_tag_t            tag;
  logic [WIN_W-1:0]     mask;
  logic [POS_W-1:0]     pos;

  logic [ADDR_W-1:0]    word_index;
  logic [WORD_BITS-1:0] word_data;
  logic [RUN_W-1:0]     run_length;

  // unpack the request
  assign word_index = s_axis_tdata[ADDR_W-1:0];
  assign word_data  = s_axis_tdata[ADDR_W +: WORD_BITS];
  assign run_length = s_axis_tdata[ADDR_W+WORD_BITS +: RUN_W];

  // words_in_use register, clamped to the store depth
  always_comb begin
    words_d = cfg_we_i ? cfg_wdata_i : words_q;
    limit   = (words_q > CNT_W'(BITMAP_WORDS)) ? CNT_W'(BITMAP_WORDS) : words_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= CNT_W'(CFG_RESET);
    end else begin
      words_q <= words_d;
    end
  end

  // store writes on an accepted write request
  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign st_we    = s_accept && (s_axis_tuser == KIND_WRITE);

  bfrf_store u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (word_index),
    .wdata_i (word_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  bfrf_run_unit u_run (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .rdata_i (rdata),
    .mask_o  (mask),
    .tag_o   (tag)
  );

  bfrf_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .kind_i       (s_axis_tuser),
    .run_length_i (run_length),
    .limit_i      (limit),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .ctl_o        (ctl),
    .mask_i       (mask),
    .tag_i        (tag),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .found_o      (m_axis_tuser),
    .pos_o        (pos)
  );

  assign m_axis_tdata = {4'b0000, pos};

endmodule
`default_nettype wire

>>> rtl/bfrf_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfrf_store : bitmap word memory
// One write port and one read port with registered read data.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module bfrf_store
  import bfrf_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [ADDR_W-1:0]    waddr_i,
  input  wire logic [WORD_BITS-1:0] wdata_i,
  input  wire logic                 re_i,
  input  wire logic [ADDR_W-1:0]    raddr_i,
  output logic      [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem_q [BITMAP_WORDS];
  logic [WORD_BITS-1:0] rdata_q;

  // write one word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/bfrf_run_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfrf_run_unit : shared run mask unit
// Builds a two-word window from the previous and current free bits and marks
// every start position that is followed by run_len free bits. The mask and
// the word tag are registered for the sequencer.
// ----------------------------------------------------------------------------
module bfrf_run_unit
  import bfrf_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire bfrf_ctl_t            ctl_i,
  input  wire logic [WORD_BITS-1:0] rdata_i,
  output logic      [WIN_W-1:0]     mask_o,
  output bfrf_tag_t                 tag_o
);

  logic [WORD_BITS-1:0] prev_q, prev_d;
  logic [WIN_W-1:0]     mask_q, mask_d;
  bfrf_tag_t            tag_q, tag_d;

  logic [WIN_W-1:0]     win;
  logic [WIN_W-1:0]     lvl [LVL_N];
  logic [LVL_W-1:0]     k;
  logic [RUN_W-1:0]     pow;
  logic [SHF_W-1:0]     rem;

  // doubling levels: lvl[j] marks starts of 2**j free bits
  always_comb begin
    win    = {~rdata_i, prev_q};
    lvl[0] = win;
    for (int j = 1; j < LVL_N; j++) begin
      lvl[j] = lvl[j-1] & (lvl[j-1] >> (1 << (j-1)));
    end
  end

  // split run_len into the highest power of two and a remainder
  always_comb begin
    k = '0;
    for (int i = 0; i < LVL_N; i++) begin
      if (ctl_i.run_len[i]) begin
        k = LVL_W'(i);
      end
    end
    pow  = RUN_W'(1) << k;
    rem  = SHF_W'(ctl_i.run_len - pow);
    mask_d = lvl[k] & (lvl[k] >> rem);
  end

  // advance the window and the tag
  always_comb begin
    prev_d = prev_q;
    tag_d  = ctl_i.tag;
    if (ctl_i.clr) begin
      prev_d    = '0;
      tag_d.vld = 1'b0;
    end else if (ctl_i.tag.vld) begin
      prev_d = ~rdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      tag_q  <= '0;
    end else begin
      prev_q <= prev_d;
      tag_q  <= tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
  end

  assign mask_o = mask_q;
  assign tag_o  = tag_q;

endmodule
`default_nettype wire

>>> rtl/bfrf_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfrf_seq : search sequencer
// Takes requests, issues one bitmap read per cycle, picks the lowest start
// from the run mask and holds the result in the output register.
// ----------------------------------------------------------------------------
module bfrf_seq
  import bfrf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_valid_i,
  output logic                   s_ready_o,
  input  wire logic              kind_i,
  input  wire logic [RUN_W-1:0]  run_length_i,
  input  wire logic [CNT_W-1:0]  limit_i,
  output logic                   rd_en_o,
  output logic [ADDR_W-1:0]      rd_addr_o,
  output bfrf_ctl_t              ctl_o,
  input  wire logic [WIN_W-1:0]  mask_i,
  input  wire bfrf_tag_t         tag_i,
  output logic                   m_valid_o,
  input  wire logic              m_ready_i,
  output logic                   found_o,
  output logic [POS_W-1:0]       pos_o
);

  bfrf_state_e       state_q, state_d;
  logic [CNT_W-1:0]  iss_q, iss_d;
  logic [CNT_W-1:0]  limit_q, limit_d;
  logic [RUN_W-1:0]  n_q, n_d;
  bfrf_tag_t         tag_q, tag_d;
  logic              res_found_q, res_found_d;
  logic [POS_W-1:0]  res_pos_q, res_pos_d;
  logic              out_vld_q, out_vld_d;
  logic              out_found_q, out_found_d;
  logic [POS_W-1:0]  out_pos_q, out_pos_d;

  logic              accept, find_go, empty_run, no_run, hit, out_free;
  logic [SEL_W-1:0]  sel;
  logic [POS_W:0]    pos_full;

  assign accept    = s_valid_i && (state_q == ST_IDLE);
  assign find_go   = accept && (kind_i == KIND_FIND);
  assign empty_run = (run_length_i == '0);
  assign no_run    = (run_length_i > RUN_W'(MAX_RUN)) || (limit_i == '0);
  assign hit       = |mask_i;
  assign out_free  = !out_vld_q || m_ready_i;

  // lowest start in the window
  always_comb begin
    sel = '0;
    for (int i = WIN_W - 1; i >= 0; i--) begin
      if (mask_i[i]) begin
        sel = SEL_W'(i);
      end
    end
    pos_full = (POS_W+1)'({tag_i.widx, SHF_W'(0)}) + (POS_W+1)'(sel)
             - (POS_W+1)'(WORD_BITS);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (find_go) begin
          state_d = (empty_run || no_run) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tag_i.vld && (hit || tag_i.last)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_ready_o     = (state_q == ST_IDLE);
    rd_en_o       = (state_q == ST_SCAN) && (iss_q < limit_q);
    rd_addr_o     = iss_q[ADDR_W-1:0];
    ctl_o.clr     = find_go;
    ctl_o.run_len = n_q;
    ctl_o.tag     = tag_q;
  end

  // counters, search settings and result
  always_comb begin
    iss_d       = iss_q;
    limit_d     = limit_q;
    n_d         = n_q;
    res_found_d = res_found_q;
    res_pos_d   = res_pos_q;
    tag_d.vld   = rd_en_o;
    tag_d.last  = (iss_q == limit_q - CNT_W'(1));
    tag_d.widx  = iss_q[ADDR_W-1:0];
    if (find_go) begin
      iss_d       = '0;
      limit_d     = limit_i;
      n_d         = run_length_i;
      res_found_d = empty_run;
      res_pos_d   = '0;
    end else if (rd_en_o) begin
      iss_d = iss_q + CNT_W'(1);
    end
    if ((state_q == ST_SCAN) && tag_i.vld) begin
      if (hit) begin
        res_found_d = 1'b1;
        res_pos_d   = pos_full[POS_W-1:0];
      end else if (tag_i.last) begin
        res_found_d = 1'b0;
        res_pos_d   = '0;
      end
    end
  end

  // output register
  always_comb begin
    out_vld_d   = out_vld_q;
    out_found_d = out_found_q;
    out_pos_d   = out_pos_q;
    if ((state_q == ST_DONE) && out_free) begin
      out_vld_d   = 1'b1;
      out_found_d = res_found_q;
      out_pos_d   = res_pos_q;
    end else if (m_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      iss_q     <= '0;
      tag_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      iss_q     <= iss_d;
      tag_q     <= tag_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    limit_q     <= limit_d;
    n_q         <= n_d;
    res_found_q <= res_found_d;
    res_pos_q   <= res_pos_d;
    out_found_q <= out_found_d;
    out_pos_q   <= out_pos_d;
  end

  assign m_valid_o = out_vld_q;
  assign found_o   = out_found_q;
  assign pos_o     = out_pos_q;

  // a find request always leaves idle
  a_find_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == KIND_FIND)) |=> (state_q != ST_IDLE))
    else $error("find request did not start a search");

  // a write request keeps the sequencer idle
  a_write_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == KIND_WRITE)) |=> (state_q == ST_IDLE))
    else $error("write request left idle");

  // a result is only loaded on leaving the done state
  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == ST_DONE))
    else $error("result loaded outside done state");

  // reads never run past the words in use
  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (iss_q <= limit_q))
    else $error("read issued beyond the words in use");

endmodule
`default_nettype wire
